FILE: rtl/dqsdwt_pkg.sv
// ---------------------------------------------------------------------------
// dqsdwt_pkg - shared types and codes
// Word formats, register indexes and result action codes for the DQS
// read-delay window training block.
// ---------------------------------------------------------------------------
package dqsdwt_pkg;

  localparam logic [31:0] RAMP_STEP     = 32'h1111_1111;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam int unsigned PASSES_NEEDED = 3;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [1:0] REG_LANE_SELECT  = 2'd1;

  // lane_select at or above this compares the whole word
  localparam logic [2:0] LANE_WHOLE = 3'd4;

  // result action codes
  localparam logic [1:0] ACT_RETEST = 2'd0;
  localparam logic [1:0] ACT_NEXT   = 2'd1;
  localparam logic [1:0] ACT_OK     = 2'd2;
  localparam logic [1:0] ACT_FAIL   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic        transfer_ok;
    logic [1:0]  action;
    logic [7:0]  next_tap;
    logic [7:0]  first_edge;
    logic [7:0]  last_edge;
    logic [7:0]  center_tap;
    logic [31:0] center_word;
  } out_word_t;

  // event passed from the checker front end to the sweep back end
  typedef struct packed {
    logic is_start;
    logic ok;
  } evt_t;

  function automatic logic [7:0] tap_mid(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8:1];
  endfunction

  function automatic logic [31:0] mid_word(input logic [7:0] c, input logic [2:0] lane);
    return (lane >= LANE_WHOLE) ? {4{c}} : {24'd0, c};
  endfunction

endpackage

FILE: rtl/dqs_delay_window_training_top.sv
// ---------------------------------------------------------------------------
// dqs_delay_window_training_top - DQS read-delay window centering
// Pattern checker, event queue and tap sweep sequencer with result queue.
// ---------------------------------------------------------------------------
// Usage:
//  Input words (in_data) are pushed with in_push while in_full is low. A
//  start word (kind 1) resets the sweep to tap 0; data words are checked
//  against the toggle or ramp pattern and the word marked last_word ends a
//  test transfer, which yields exactly one result word.
//  Results wait in a two-word queue: out_data is valid while out_empty is
//  low and is taken with out_pop.
//  Config: cfg_valid with cfg_index/cfg_data writes a register; cfg_ready
//  is always high. Write only while the block is idle.
//  Timing: one input word per clock while in_full is low. A result is
//  registered twice on its way out: the transfer-end word writes an event
//  into the event queue, the sequencer then writes the result into the
//  result queue, where it can be popped. The sweep sequencer takes one
//  event per clock while the result queue has room (start events need none).
//  Reset (rst_n low, synchronous) empties both queues, idles the sweep and
//  loads pattern_mode 1 and lane_select 4.
//  Stall: when out_pop stays low the result queue fills, the sequencer
//  holds, then the event queue fills and in_full rises.
// ---------------------------------------------------------------------------
module dqs_delay_window_training_top #(
  parameter int TAP_STEPS     = 64,
  parameter int TAP_INCREMENT = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  dqsdwt_pkg::in_word_t   in_data,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output dqsdwt_pkg::out_word_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [2:0]             cfg_data
);
  import dqsdwt_pkg::*;

  localparam int EW = $bits(evt_t);
  localparam int OW = $bits(out_word_t);

  logic       pattern_mode_r;
  logic [2:0] lane_select_r;

  logic       in_accept;
  logic       fe_valid;
  evt_t       fe_evt;
  logic       q_full, q_empty, q_pop;
  logic [EW-1:0] q_rdata;
  evt_t       be_evt;
  logic       res_valid, res_full;
  out_word_t  res;
  logic [OW-1:0] out_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_mode_r <= 1'b1;
      lane_select_r  <= LANE_WHOLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_MODE: pattern_mode_r <= cfg_data[0];
        REG_LANE_SELECT:  lane_select_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  dqsdwt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .word         (in_data),
    .pattern_mode (pattern_mode_r),
    .lane_select  (lane_select_r),
    .evt_valid    (fe_valid),
    .evt          (fe_evt)
  );

  dqsdwt_fifo #(.W(EW)) u_evt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_valid),
    .wdata (fe_evt),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // a start event needs no result slot
  assign be_evt = evt_t'(q_rdata);
  assign q_pop  = !q_empty && (be_evt.is_start || !res_full);

  dqsdwt_back #(
    .TAP_STEPS     (TAP_STEPS),
    .TAP_INCREMENT (TAP_INCREMENT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (q_pop),
    .evt         (be_evt),
    .lane_select (lane_select_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  dqsdwt_fifo #(.W(OW)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_data = out_word_t'(out_rdata);

endmodule

FILE: rtl/dqsdwt_fifo.sv
// ---------------------------------------------------------------------------
// dqsdwt_fifo - two-entry word queue
// Flop-based queue with registered fill count; used between front and back
// end and as the result buffer.
// ---------------------------------------------------------------------------
module dqsdwt_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/dqsdwt_front.sv
// ---------------------------------------------------------------------------
// dqsdwt_front - read-back pattern checker
// Compares each word against the toggle or ramp pattern and raises one
// event per start command or transfer end.
// ---------------------------------------------------------------------------
module dqsdwt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  dqsdwt_pkg::in_word_t  word,
  input  logic                  pattern_mode,
  input  logic [2:0]            lane_select,
  output logic                  evt_valid,
  output dqsdwt_pkg::evt_t      evt
);
  import dqsdwt_pkg::*;

  logic [31:0] exp_word_r, exp_word_nxt;
  logic        parity_r, parity_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [31:0] ref_word, mask;
  logic        miss;

  always_comb begin
    ref_word = pattern_mode ? exp_word_r : (parity_r ? ALL_ONES : 32'd0);
    mask     = (lane_select < LANE_WHOLE) ? (32'hFF << {lane_select[1:0], 3'b000}) : ALL_ONES;
    miss     = mismatch_r | (((word.read_word ^ ref_word) & mask) != 32'd0);
  end

  always_comb begin
    exp_word_nxt = exp_word_r;
    parity_nxt   = parity_r;
    mismatch_nxt = mismatch_r;
    evt_valid    = 1'b0;
    evt.is_start = word.kind;
    evt.ok       = !miss;
    if (accept) begin
      if (word.kind || word.last_word) begin
        exp_word_nxt = 32'd0;
        parity_nxt   = 1'b0;
        mismatch_nxt = 1'b0;
        evt_valid    = 1'b1;
      end else begin
        exp_word_nxt = exp_word_r + RAMP_STEP;
        parity_nxt   = !parity_r;
        mismatch_nxt = miss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_word_r <= 32'd0;
      parity_r   <= 1'b0;
      mismatch_r <= 1'b0;
    end else begin
      exp_word_r <= exp_word_nxt;
      parity_r   <= parity_nxt;
      mismatch_r <= mismatch_nxt;
    end
  end

endmodule

FILE: rtl/dqsdwt_back.sv
// ---------------------------------------------------------------------------
// dqsdwt_back - delay sweep sequencer
// Steps the tap sweep after a run of passes or a fail while searching,
// retests otherwise, tracks the passing window and builds the result word.
// ---------------------------------------------------------------------------
module dqsdwt_back #(
  parameter int TAP_STEPS     = 64,
  parameter int TAP_INCREMENT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  dqsdwt_pkg::evt_t      evt,
  input  logic [2:0]            lane_select,
  output logic                  res_valid,
  output dqsdwt_pkg::out_word_t res
);
  import dqsdwt_pkg::*;

  localparam int TIW = $clog2(TAP_STEPS + 1);
  localparam int PW  = TIW + 13;
  localparam logic [7:0] LAST_TAP = 8'(((TAP_STEPS - 1) * TAP_INCREMENT) % 256);
  localparam logic [7:0] TAP_INC  = 8'(TAP_INCREMENT);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_WINDOW = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [1:0]     phase_r, phase_nxt;
  logic [1:0]     pass_run_r, pass_run_nxt;
  logic [TIW-1:0] tap_idx_r, tap_idx_nxt;
  logic [7:0]     win_start_r, win_start_nxt;

  logic [PW-1:0]  tap_prod;
  logic [7:0]     cur_tap, nxt_tap, fail_last, ctr_fail, ctr_end, ws_eff;
  logic           entering, in_win;

  always_comb begin
    tap_prod  = PW'(tap_idx_r) * PW'(TAP_INCREMENT);
    cur_tap   = tap_prod[7:0];
    nxt_tap   = cur_tap + TAP_INC;
    fail_last = cur_tap - TAP_INC;
    ctr_fail  = tap_mid(win_start_r, fail_last);
    entering  = evt.ok && (phase_r == PH_SEARCH);
    ws_eff    = entering ? cur_tap : win_start_r;
    in_win    = entering || (phase_r == PH_WINDOW);
    ctr_end   = tap_mid(ws_eff, LAST_TAP);
  end

  always_comb begin
    phase_nxt       = phase_r;
    pass_run_nxt    = pass_run_r;
    tap_idx_nxt     = tap_idx_r;
    win_start_nxt   = win_start_r;
    res_valid       = fire && !evt.is_start;
    res             = '0;
    res.transfer_ok = evt.ok;
    res.action      = ACT_RETEST;
    res.next_tap    = cur_tap;
    if (fire) begin
      if (evt.is_start) begin
        phase_nxt     = PH_SEARCH;
        pass_run_nxt  = 2'd0;
        tap_idx_nxt   = '0;
        win_start_nxt = 8'd0;
      end else if (phase_r == PH_WINDOW && !evt.ok) begin
        // first failure inside the window closes it one tap back
        phase_nxt       = PH_DONE;
        pass_run_nxt    = 2'd0;
        res.action      = ACT_OK;
        res.next_tap    = ctr_fail;
        res.first_edge  = win_start_r;
        res.last_edge   = fail_last;
        res.center_tap  = ctr_fail;
        res.center_word = mid_word(ctr_fail, lane_select);
      end else if (phase_r == PH_SEARCH || phase_r == PH_WINDOW) begin
        if (evt.ok && pass_run_r != 2'(PASSES_NEEDED - 1)) begin
          pass_run_nxt   = pass_run_r + 2'd1;
          res.first_edge = win_start_r;
        end else begin
          pass_run_nxt  = 2'd0;
          tap_idx_nxt   = tap_idx_r + TIW'(1);
          win_start_nxt = ws_eff;
          phase_nxt     = in_win ? PH_WINDOW : phase_r;
          if (tap_idx_r == TIW'(TAP_STEPS - 1)) begin
            if (in_win) begin
              phase_nxt       = PH_DONE;
              res.action      = ACT_OK;
              res.next_tap    = ctr_end;
              res.first_edge  = ws_eff;
              res.last_edge   = LAST_TAP;
              res.center_tap  = ctr_end;
              res.center_word = mid_word(ctr_end, lane_select);
            end else begin
              phase_nxt     = PH_IDLE;
              win_start_nxt = 8'd0;
              res.action    = ACT_FAIL;
              res.next_tap  = 8'd0;
            end
          end else begin
            res.action     = ACT_NEXT;
            res.next_tap   = nxt_tap;
            res.first_edge = ws_eff;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pass_run_r  <= 2'd0;
      tap_idx_r   <= '0;
      win_start_r <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      pass_run_r  <= pass_run_nxt;
      tap_idx_r   <= tap_idx_nxt;
      win_start_r <= win_start_nxt;
    end
  end

endmodule
